// ----- rtl/wsfc_pkg.sv -----
// Shared types, constants and tables of the windowed-sinc coefficient generator
`timescale 1ns / 1ps
package wsfc_pkg;

  localparam int TAP_W      = 8;
  localparam int NT_W       = 9;
  localparam int CUT_W      = 16;
  localparam int WK_W       = 2;
  localparam int COEF_W     = 18;
  localparam int TPOS_W     = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int DEF_MAX_TAPS  = 256;
  localparam int CORDIC_STAGES = 24;
  localparam int CW            = 34;  // cordic x/y width
  localparam int ZW            = 33;  // cordic angle width

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [31:0]          PI_Q30      = 32'd3373259426;
  localparam logic [31:0]          INV_PI_Q32  = 32'd1367130551;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_TAPS,
    CFG_CUTOFF,
    CFG_WINDOW,
    CFG_RESPONSE
  } cfg_idx_e;

  typedef enum logic [WK_W-1:0] {
    WIN_RECT,
    WIN_HAMMING,
    WIN_HANN,
    WIN_BLACKMAN
  } win_kind_e;

  typedef struct packed {
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
  } win_coef_t;

  typedef struct packed {
    logic v;
    logic inv;
    logic odd;
  } sb_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef;
    logic [TPOS_W-1:0]        tpos;
    logic                     inv;
  } rsp_t;

  // window = a - b*cos(p) + c*cos(2p), all in Q0.16
  function automatic win_coef_t wsfc_win_coef(input win_kind_e k);
    win_coef_t r;
    unique case (k)
      WIN_RECT:     r = '{a: 16'd0,     b: 16'd0,     c: 16'd0};
      WIN_HAMMING:  r = '{a: 16'd35389, b: 16'd30147, c: 16'd0};
      WIN_HANN:     r = '{a: 16'd32768, b: 16'd32768, c: 16'd0};
      WIN_BLACKMAN: r = '{a: 16'd27525, b: 16'd32768, c: 16'd5243};
      default:      r = '{a: 16'd0,     b: 16'd0,     c: 16'd0};
    endcase
    return r;
  endfunction

  // truncated atan(2^-i) in Q2.30
  function automatic logic signed [ZW-1:0] wsfc_atan(input logic [4:0] idx);
    logic signed [ZW-1:0] r;
    case (idx)
      5'd0:  r = 33'sd843314856;
      5'd1:  r = 33'sd497837829;
      5'd2:  r = 33'sd263043836;
      5'd3:  r = 33'sd133525158;
      5'd4:  r = 33'sd67021686;
      5'd5:  r = 33'sd33543515;
      5'd6:  r = 33'sd16775850;
      5'd7:  r = 33'sd8388437;
      5'd8:  r = 33'sd4194282;
      5'd9:  r = 33'sd2097149;
      5'd10: r = 33'sd1048575;
      5'd11: r = 33'sd524287;
      5'd12: r = 33'sd262143;
      5'd13: r = 33'sd131071;
      5'd14: r = 33'sd65535;
      5'd15: r = 33'sd32767;
      5'd16: r = 33'sd16383;
      5'd17: r = 33'sd8191;
      5'd18: r = 33'sd4095;
      5'd19: r = 33'sd2047;
      5'd20: r = 33'sd1023;
      5'd21: r = 33'sd511;
      5'd22: r = 33'sd255;
      5'd23: r = 33'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/wsfc_if.sv -----
// Request and response channel interfaces of the coefficient generator
`timescale 1ns / 1ps
interface wsfc_tap_if import wsfc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [TAP_W-1:0] tap_index;
  modport source (output valid, output tap_index, input ready);
  modport sink (input valid, input tap_index, output ready);
endinterface

interface wsfc_coef_if import wsfc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [COEF_W-1:0] coefficient;
  logic [TPOS_W-1:0]        time_position;
  logic                     index_invalid;
  modport source (output valid, output coefficient, output time_position,
                  output index_invalid, input ready);
  modport sink (input valid, input coefficient, input time_position,
                input index_invalid, output ready);
endinterface

// ----- rtl/wsfc_delay.sv -----
// Enabled shift line that aligns data between pipeline branches
`timescale 1ns / 1ps
module wsfc_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] pipe_q [0:D-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < D; i++) pipe_q[i] <= '0;
    end else if (en_i) begin
      pipe_q[0] <= d_i;
      for (int i = 1; i < D; i++) pipe_q[i] <= pipe_q[i-1];
    end
  end

  assign q_o = pipe_q[D-1];

endmodule

// ----- rtl/wsfc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module wsfc_div #(
  parameter int DW = 40,
  parameter int VW = 9,
  parameter int QW = 33
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic [QW-1:0] quotient_o
);

  localparam int W = VW + QW;

  logic [W-1:0]  rem_q [1:QW];
  logic [VW-1:0] dvs_q [1:QW];
  logic [QW-1:0] quo_q [1:QW];

  logic [W-1:0]  rem_in [0:QW-1];
  logic [VW-1:0] dvs_in [0:QW-1];
  logic [QW-1:0] quo_in [0:QW-1];
  logic [W-1:0]  sub_v  [0:QW-1];

  always_comb begin
    rem_in[0] = W'(dividend_i);
    dvs_in[0] = divisor_i;
    quo_in[0] = '0;
    for (int s = 1; s < QW; s++) begin
      rem_in[s] = rem_q[s];
      dvs_in[s] = dvs_q[s];
      quo_in[s] = quo_q[s];
    end
    for (int s = 0; s < QW; s++) begin
      sub_v[s] = W'(dvs_in[s]) << (QW - 1 - s);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < QW; s++) begin
        dvs_q[s+1] <= dvs_in[s];
        if (rem_in[s] >= sub_v[s]) begin
          rem_q[s+1] <= rem_in[s] - sub_v[s];
          quo_q[s+1] <= quo_in[s] | (QW'(1) << (QW - 1 - s));
        end else begin
          rem_q[s+1] <= rem_in[s];
          quo_q[s+1] <= quo_in[s];
        end
      end
    end
  end

  assign quotient_o = quo_q[QW];

endmodule

// ----- rtl/wsfc_cordic.sv -----
// Pipelined rotation cordic giving sine or cosine of a phase in turns
`timescale 1ns / 1ps
module wsfc_cordic import wsfc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [31:0]          phase_i,
  input  logic                 cos_sel_i,
  output logic signed [CW-1:0] result_o
);

  logic [61:0]          zprod;
  logic signed [CW-1:0] x_q [0:CORDIC_STAGES];
  logic signed [CW-1:0] y_q [0:CORDIC_STAGES];
  logic signed [ZW-1:0] z_q [0:CORDIC_STAGES];
  logic [1:0]           quad_q [0:CORDIC_STAGES];
  logic signed [CW-1:0] sn, cs;
  logic signed [CW-1:0] res_q;

  // angle within the quadrant in radians, Q2.30
  assign zprod = 62'(phase_i[29:0]) * 62'(PI_Q30);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= CORDIC_GAIN;
      y_q[0]    <= '0;
      z_q[0]    <= $signed({2'b00, zprod[61:31]});
      quad_q[0] <= phase_i[31:30];
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        quad_q[i+1] <= quad_q[i];
        if (!z_q[i][ZW-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - wsfc_atan(5'(i));
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + wsfc_atan(5'(i));
        end
      end
      res_q <= cos_sel_i ? cs : sn;
    end
  end

  // fold back to the full turn
  always_comb begin
    case (quad_q[CORDIC_STAGES])
      2'd0: begin
        sn = y_q[CORDIC_STAGES];
        cs = x_q[CORDIC_STAGES];
      end
      2'd1: begin
        sn = x_q[CORDIC_STAGES];
        cs = -y_q[CORDIC_STAGES];
      end
      2'd2: begin
        sn = -y_q[CORDIC_STAGES];
        cs = -x_q[CORDIC_STAGES];
      end
      default: begin
        sn = -x_q[CORDIC_STAGES];
        cs = y_q[CORDIC_STAGES];
      end
    endcase
  end

  assign result_o = res_q;

endmodule

// ----- rtl/windowed_sinc_fir_coeff_gen.sv -----
// Top level of the windowed-sinc FIR coefficient generator
//
// Requests arrive on tap_in (valid/ready) and carry one tap index n. Each
// request returns one response on coef_out: the windowed tap h[n] in Q1.16,
// the position n/(M-1) in Q1.16 and a flag for n >= M (then both are zero).
// The configuration port writes num_taps, cutoff_ratio, window_kind and
// response_kind by index on any cycle with cfg_we_i high; write it only
// while no request is in flight.
// Throughput is one request per cycle while the output buffer has room. The
// depth from a request to its response is set by the 33-stage divider for
// the window phase followed by the 26-stage cosine cordic and the final
// multiply and rounding stages.
// Responses collect in a two-entry output buffer. While the receiver stalls
// the buffer fills and then the whole pipeline holds, dropping ready; no
// request is lost or repeated.
// Reset restores num_taps 64, cutoff 8192, Hamming window and low-pass
// response, and empties the pipeline.
`timescale 1ns / 1ps
module windowed_sinc_fir_coeff_gen import wsfc_pkg::*; #(
  parameter int MAX_TAPS = DEF_MAX_TAPS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  wsfc_tap_if.sink              tap_in,
  wsfc_coef_if.source           coef_out
);

  localparam int SD_W = 2 * NT_W + 1;  // quotient bits of the sinc divider

  // configuration
  logic [NT_W-1:0]  num_taps_q;
  logic [CUT_W-1:0] cutoff_q;
  win_kind_e        win_q;
  logic             resp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_taps_q <= NT_W'(64);
      cutoff_q   <= CUT_W'(8192);
      win_q      <= WIN_HAMMING;
      resp_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_NUM_TAPS: num_taps_q <= cfg_wdata_i[NT_W-1:0];
        CFG_CUTOFF:   cutoff_q   <= cfg_wdata_i[CUT_W-1:0];
        CFG_WINDOW:   win_q      <= win_kind_e'(cfg_wdata_i[WK_W-1:0]);
        CFG_RESPONSE: resp_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  logic [NT_W-1:0] m, m1;

  always_comb begin
    m = num_taps_q;
    if (num_taps_q < NT_W'(2)) m = NT_W'(2);
    else if (32'(num_taps_q) > MAX_TAPS) m = NT_W'(MAX_TAPS);
  end
  assign m1 = m - NT_W'(1);

  // pipeline enable: the output buffer has room
  logic [1:0] cnt_q;
  logic       en;
  assign en           = (cnt_q != 2'd2);
  assign tap_in.ready = en;

  // input stage: offset from centre and sinc phase
  logic [NT_W-1:0]  two_n, ad;
  logic [24:0]      adc;
  logic             v0_q, inv0_q, odd0_q, adz0_q;
  logic [TAP_W-1:0] n0_q;
  logic [NT_W-1:0]  ad0_q;
  logic [31:0]      p0_q;

  assign two_n = {tap_in.tap_index, 1'b0};
  assign ad    = (two_n < m1) ? (m1 - two_n) : (two_n - m1);
  assign adc   = 25'(ad) * 25'(cutoff_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= tap_in.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n0_q   <= tap_in.tap_index;
      inv0_q <= (NT_W'(tap_in.tap_index) >= m);
      odd0_q <= tap_in.tap_index[0];
      adz0_q <= (ad == '0);
      ad0_q  <= ad;
      p0_q   <= {adc[16:0], 15'd0};
    end
  end

  // sinc branch
  logic signed [CW-1:0] s_sin, s_abs;
  logic [62:0]          mag_q;
  logic                 sneg_q;
  logic [NT_W-1:0]      ad27, ad28_q;
  logic [63:0]          dsum;
  logic [SD_W-1:0]      dq_q, hq;
  logic                 adz47, sneg47;
  logic signed [COEF_W-1:0] h_q, h61;

  wsfc_cordic u_sinc_cordic (
    .clk_i     (clk_i),
    .en_i      (en),
    .phase_i   (p0_q),
    .cos_sel_i (1'b0),
    .result_o  (s_sin)
  );

  assign s_abs = s_sin[CW-1] ? -s_sin : s_sin;

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q  <= 63'(s_abs[31:0]) * 63'(INV_PI_Q32);
      sneg_q <= s_sin[CW-1];
    end
  end

  wsfc_delay #(.W(NT_W), .D(27)) u_ad_dly (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .d_i (ad0_q), .q_o (ad27)
  );

  // rounding term folded into the dividend, then scaled down by 2^45
  assign dsum = 64'(mag_q) + (64'(ad27) << 44);

  always_ff @(posedge clk_i) begin
    if (en) begin
      dq_q   <= dsum[63:45];
      ad28_q <= ad27;
    end
  end

  wsfc_div #(.DW(SD_W), .VW(NT_W), .QW(SD_W)) u_sinc_div (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (dq_q),
    .divisor_i  (ad28_q),
    .quotient_o (hq)
  );

  wsfc_delay #(.W(1), .D(47)) u_adz_dly (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .d_i (adz0_q), .q_o (adz47)
  );

  wsfc_delay #(.W(1), .D(20)) u_sgn_dly (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .d_i (sneg_q), .q_o (sneg47)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (adz47)       h_q <= COEF_W'({cutoff_q, 1'b0});
      else if (sneg47) h_q <= -COEF_W'(hq);
      else             h_q <= COEF_W'(hq);
    end
  end

  wsfc_delay #(.W(COEF_W), .D(13)) u_h_dly (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .d_i (h_q), .q_o (h61)
  );

  // window branch
  logic [32:0]          wq;
  logic signed [CW-1:0] c1, c2;
  logic signed [50:0]   p1_q, p2_q;
  logic signed [52:0]   acc;
  logic signed [18:0]   w_q;
  logic [TPOS_W-1:0]    tpos61, tpos62_q;
  win_coef_t            wc;

  wsfc_div #(.DW(TAP_W + 32), .VW(NT_W), .QW(33)) u_win_div (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i ({n0_q, 32'd0}),
    .divisor_i  (m1),
    .quotient_o (wq)
  );

  wsfc_cordic u_cos1 (
    .clk_i     (clk_i),
    .en_i      (en),
    .phase_i   (wq[31:0]),
    .cos_sel_i (1'b1),
    .result_o  (c1)
  );

  wsfc_cordic u_cos2 (
    .clk_i     (clk_i),
    .en_i      (en),
    .phase_i   ({wq[30:0], 1'b0}),
    .cos_sel_i (1'b1),
    .result_o  (c2)
  );

  wsfc_delay #(.W(TPOS_W), .D(28)) u_tpos_dly (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .d_i (wq[32:16]), .q_o (tpos61)
  );

  assign wc  = wsfc_win_coef(win_q);
  assign acc = $signed({7'd0, wc.a, 30'd0}) - 53'(p1_q) + 53'(p2_q)
             + 53'sd536870912;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q <= 51'($signed({1'b0, wc.b})) * 51'(c1);
      p2_q <= 51'($signed({1'b0, wc.c})) * 51'(c2);
      if (win_q == WIN_RECT) w_q <= 19'sd65536;
      else                   w_q <= 19'(acc >>> 30);
    end
  end

  // tap product
  logic signed [36:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q   <= 37'(h61) * 37'(w_q);
      tpos62_q <= tpos61;
    end
  end

  sb_t sb0, sb62;
  assign sb0 = '{v: v0_q, inv: inv0_q, odd: odd0_q};

  wsfc_delay #(.W($bits(sb_t)), .D(62)) u_sb_dly (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .d_i (sb0), .q_o (sb62)
  );

  // rounding, sign flip and saturation
  logic signed [37:0] rnd;
  logic signed [21:0] t0, t1;
  logic signed [COEF_W-1:0] tap_sat;
  rsp_t rsp_new;

  always_comb begin
    rnd = (38'(prod_q) + 38'sd32768) >>> 16;
    t0  = rnd[21:0];
    t1  = (resp_q && sb62.odd) ? -t0 : t0;
    if (t1 > 22'sd131071)       tap_sat = 18'sd131071;
    else if (t1 < -22'sd131072) tap_sat = -18'sd131072;
    else                        tap_sat = t1[COEF_W-1:0];
    if (sb62.inv) rsp_new = '{coef: '0, tpos: '0, inv: 1'b1};
    else          rsp_new = '{coef: tap_sat, tpos: tpos62_q, inv: 1'b0};
  end

  // two-entry output buffer
  rsp_t buf_q [0:1];
  logic push, pop;

  assign push = en && sb62.v;
  assign pop  = coef_out.valid && coef_out.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case ({push, pop})
      2'b10: buf_q[cnt_q[0]] <= rsp_new;
      2'b01: buf_q[0] <= buf_q[1];
      2'b11: buf_q[0] <= rsp_new;
      default: ;
    endcase
  end

  assign coef_out.valid         = (cnt_q != 2'd0);
  assign coef_out.coefficient   = buf_q[0].coef;
  assign coef_out.time_position = buf_q[0].tpos;
  assign coef_out.index_invalid = buf_q[0].inv;

endmodule

// ----- tb/wsfc_coef_checker.sv -----
// Checker: predicts each windowed-sinc tap and compares it with the block's responses
`timescale 1ns / 1ps
module wsfc_coef_checker import wsfc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  wsfc_tap_if                   tap,
  wsfc_coef_if                  coef,
  output int                    errors_o,
  output int                    pending_o
);

  localparam longint ATAN_Q30 [24] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767, 16383, 8191,
    4095, 2047, 1023, 511, 255, 127
  };

  logic [NT_W-1:0]  num_taps_q;
  logic [CUT_W-1:0] cutoff_q;
  win_kind_e        win_q;
  logic             modulated_q;
  rsp_t             want_q[$];

  // sine and cosine of a Q0.32 turn, both Q2.30
  function automatic void turn_sincos(input logic [31:0] p, output longint sn,
                                      output longint cs);
    longint x, y, z, xs, ys;
    longint unsigned prod;
    prod = longint'(p[29:0]) * longint'(PI_Q30);
    z = longint'(prod >> 31);
    x = longint'(CORDIC_GAIN);
    y = 0;
    for (int i = 0; i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - ATAN_Q30[i];
      end else begin
        x = x + ys; y = y - xs; z = z + ATAN_Q30[i];
      end
    end
    case (p[31:30])
      2'd0: begin sn = y;  cs = x;  end
      2'd1: begin sn = x;  cs = -y; end
      2'd2: begin sn = -y; cs = -x; end
      default: begin sn = -x; cs = y; end
    endcase
  endfunction

  function automatic rsp_t windowed_tap(input logic [TAP_W-1:0] n);
    rsp_t r;
    longint unsigned m, ad, mag, a, pw;
    longint h, w, t, sn, cs, c1, c2, acc;
    logic [31:0] ph;
    m = num_taps_q;
    if (m < 2) m = 2;
    if (m > DEF_MAX_TAPS) m = DEF_MAX_TAPS;
    r = '0;
    if (n >= m) begin
      r.inv = 1'b1;
      return r;
    end
    r.tpos = TPOS_W'((longint'(n) << 16) / (m - 1));
    if (2 * n < m - 1) ad = m - 1 - 2 * n;
    else ad = 2 * n - (m - 1);
    if (ad == 0) begin
      h = 2 * longint'(cutoff_q);
    end else begin
      ph = 32'((ad * longint'(cutoff_q)) << 15);
      turn_sincos(ph, sn, cs);
      mag = longint'(sn < 0 ? -sn : sn) * longint'(INV_PI_Q32);
      a = mag / ad;
      h = longint'((a + (64'd1 << 44)) >> 45);
      if (sn < 0) h = -h;
    end
    if (win_q == WIN_RECT) begin
      w = 65536;
    end else begin
      pw = (longint'(n) << 32) / (m - 1);
      turn_sincos(32'(pw), sn, c1);
      turn_sincos(32'(pw << 1), sn, c2);
      case (win_q)
        WIN_HAMMING: acc = 35389 * (64'sd1 <<< 30) - 30147 * c1;
        WIN_HANN:    acc = 32768 * (64'sd1 <<< 30) - 32768 * c1;
        default:     acc = 27525 * (64'sd1 <<< 30) - 32768 * c1 + 5243 * c2;
      endcase
      w = (acc + (64'sd1 <<< 29)) >>> 30;
    end
    t = (h * w + 32768) >>> 16;
    if (modulated_q && n[0]) t = -t;
    if (t > 131071) t = 131071;
    if (t < -131072) t = -131072;
    r.coef = COEF_W'(t);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t exp_r;
    if (!rst_ni) begin
      num_taps_q  <= NT_W'(64);
      cutoff_q    <= CUT_W'(8192);
      win_q       <= WIN_HAMMING;
      modulated_q <= 1'b0;
      want_q.delete();
      errors_o    <= 0;
    end else begin
      if (tap.valid && tap.ready) want_q.push_back(windowed_tap(tap.tap_index));
      if (coef.valid && coef.ready) begin
        if (want_q.size() == 0) begin
          $display("%0t: response with none expected: coef %0d tpos %0d inv %0b",
                   $time, coef.coefficient, coef.time_position, coef.index_invalid);
          errors_o <= errors_o + 1;
        end else begin
          exp_r = want_q.pop_front();
          if (exp_r.coef !== coef.coefficient || exp_r.tpos !== coef.time_position ||
              exp_r.inv !== coef.index_invalid) begin
            $display("%0t: mismatch expected coef %0d tpos %0d inv %0b, got %0d %0d %0b",
                     $time, exp_r.coef, exp_r.tpos, exp_r.inv, coef.coefficient,
                     coef.time_position, coef.index_invalid);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_NUM_TAPS: num_taps_q  <= cfg_wdata_i[NT_W-1:0];
          CFG_CUTOFF:   cutoff_q    <= cfg_wdata_i;
          CFG_WINDOW:   win_q       <= win_kind_e'(cfg_wdata_i[WK_W-1:0]);
          CFG_RESPONSE: modulated_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  assign pending_o = want_q.size();

endmodule

// ----- tb/windowed_sinc_fir_coeff_gen_tb.sv -----
// Testbench top: drives tap requests and configuration, gives the verdict
`timescale 1ns / 1ps
module windowed_sinc_fir_coeff_gen_tb;
  import wsfc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int FIRST_TAPS [10] = '{0, 1, 31, 32, 62, 63, 64, 85, 170, 255};

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  int                    errors, pending, cycles = 0;
  int                    idle_pct = 16;
  int                    eff_taps = 64;

  wsfc_tap_if  tap ();
  wsfc_coef_if coef ();

  always #5 clk_i = ~clk_i;

  windowed_sinc_fir_coeff_gen i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .tap_in(tap), .coef_out(coef)
  );

  wsfc_coef_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .tap(tap), .coef(coef), .errors_o(errors), .pending_o(pending)
  );

  initial begin
    tap.valid = 1'b0;
    tap.tap_index = '0;
    coef.ready = 1'b0;
  end

  always @(negedge clk_i) coef.ready = ($urandom_range(99) >= idle_pct);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("windowed_sinc_fir_coeff_gen_tb: errors");
      $finish;
    end
  end

  task automatic send_tap(input logic [TAP_W-1:0] n);
    while ($urandom_range(99) < idle_pct) begin
      tap.valid = 1'b0;
      @(negedge clk_i);
    end
    tap.valid = 1'b1;
    tap.tap_index = n;
    do @(posedge clk_i); while (!tap.ready);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int data);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = CFG_DATA_W'(data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic configure(input int nt, input int cut, input win_kind_e wk, input bit md);
    tap.valid = 1'b0;
    wait (pending == 0);
    repeat (70) @(negedge clk_i);
    write_reg(CFG_NUM_TAPS, nt);
    write_reg(CFG_CUTOFF, cut);
    write_reg(CFG_WINDOW, wk);
    write_reg(CFG_RESPONSE, md);
    eff_taps = (nt % 512 < 2) ? 2 : (nt % 512 > DEF_MAX_TAPS) ? DEF_MAX_TAPS : nt % 512;
  endtask

  task automatic random_taps(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 85) send_tap(TAP_W'($urandom_range(eff_taps - 1)));
      else send_tap(TAP_W'($urandom_range(255)));
    end
  endtask

  initial begin
    int nt, cut;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    // reset setting: edges, centre pair, out of range, alternating bits
    for (int k = 0; k < 10; k++) send_tap(TAP_W'(FIRST_TAPS[k]));
    configure(2, 1, WIN_RECT, 1'b0);
    send_tap(TAP_W'(0)); send_tap(TAP_W'(1)); send_tap(TAP_W'(2));
    random_taps(150);
    configure(256, 32768, WIN_BLACKMAN, 1'b1);
    send_tap(TAP_W'(0)); send_tap(TAP_W'(127)); send_tap(TAP_W'(128));
    send_tap(TAP_W'(255));
    random_taps(200);
    configure(0, 65535, WIN_HANN, 1'b0);       // tap count below two, cutoff above half
    random_taps(150);
    configure(511, 0, WIN_HAMMING, 1'b1);      // tap count above max, zero cutoff
    random_taps(200);
    idle_pct = 0;
    configure(255, 12345, WIN_BLACKMAN, 1'b0); // odd count, centre tap exact, no stalls
    random_taps(250);
    idle_pct = 16;
    configure(3, 32768, WIN_HAMMING, 1'b0);
    random_taps(150);
    for (int ph = 0; ph < 3; ph++) begin
      nt = $urandom_range(2, 256);
      cut = $urandom_range(1, 32768);
      configure(nt, cut, win_kind_e'($urandom_range(3)), 1'($urandom_range(1)));
      random_taps(130);
    end
    tap.valid = 1'b0;
    wait (pending == 0);
    repeat (80) @(posedge clk_i);
    if (errors == 0) $display("windowed_sinc_fir_coeff_gen_tb: clean");
    else $display("windowed_sinc_fir_coeff_gen_tb: errors");
    $finish;
  end

endmodule
